// ----- design/rdf_pkg.sv -----
package rdf_pkg;

    localparam int WHOLE_WIDTH     = 31;
    localparam int FRACTION_WIDTH  = 32;
    localparam int FRACTION_DIGITS = 10;
    localparam int BASE_WIDTH      = 5;
    localparam int DIGIT_WIDTH     = 4;
    localparam int CHAR_WIDTH      = 8;

    localparam logic [BASE_WIDTH-1:0] BASE_RESET = BASE_WIDTH'(10);
    localparam logic [BASE_WIDTH-1:0] BASE_MIN   = BASE_WIDTH'(2);
    localparam logic [BASE_WIDTH-1:0] BASE_MAX   = BASE_WIDTH'(16);

    // divider retires this many quotient bits per cycle
    localparam int DIV_BITS_PER_CYCLE = 8;
    localparam int DIV_CYCLES     = (WHOLE_WIDTH + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
    localparam int DIV_PAD_WIDTH  = DIV_CYCLES * DIV_BITS_PER_CYCLE;
    localparam int DIV_STEP_WIDTH = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam int COUNT_WIDTH = $clog2(WHOLE_WIDTH + 1);
    localparam int SENT_WIDTH  = $clog2(FRACTION_DIGITS + 1);
    localparam int PROD_WIDTH  = FRACTION_WIDTH + BASE_WIDTH;

    localparam int IN_DATA_WIDTH  = ((WHOLE_WIDTH + FRACTION_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_WIDTH = CHAR_WIDTH;

    localparam logic [CHAR_WIDTH-1:0] CHAR_POINT = 8'h2e;

    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] c;
        if (d < DIGIT_WIDTH'(10)) begin
            c = 8'h30 + {4'b0, d};
        end else begin
            c = 8'h57 + {4'b0, d};
        end
        return c;
    endfunction

endpackage

// ----- design/rdf_divider.sv -----
module rdf_divider (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [rdf_pkg::WHOLE_WIDTH-1:0]       i_dividend,
    input  logic [rdf_pkg::BASE_WIDTH-1:0]        i_divisor,
    output logic                                  o_done,
    output logic [rdf_pkg::WHOLE_WIDTH-1:0]       o_quotient,
    output logic [rdf_pkg::DIGIT_WIDTH-1:0]       o_remainder
);

    logic                                 r_busy;
    logic                                 r_done;
    logic [rdf_pkg::DIV_STEP_WIDTH-1:0]   r_step;
    logic [rdf_pkg::DIV_PAD_WIDTH-1:0]    r_acc;
    logic [rdf_pkg::DIGIT_WIDTH-1:0]      r_rem;

    logic [rdf_pkg::DIV_PAD_WIDTH-1:0]    n_acc;
    logic [rdf_pkg::DIGIT_WIDTH-1:0]      n_rem;

    // restoring long division, several bits per cycle; remainder always < divisor <= 16
    always_comb begin
        logic [rdf_pkg::DIGIT_WIDTH:0] t;
        n_acc = r_acc;
        n_rem = r_rem;
        for (int i = 0; i < rdf_pkg::DIV_BITS_PER_CYCLE; i++) begin
            t     = {n_rem, n_acc[rdf_pkg::DIV_PAD_WIDTH-1]};
            n_acc = {n_acc[rdf_pkg::DIV_PAD_WIDTH-2:0], 1'b0};
            if (t >= i_divisor) begin
                n_rem    = rdf_pkg::DIGIT_WIDTH'(t - i_divisor);
                n_acc[0] = 1'b1;
            end else begin
                n_rem = t[rdf_pkg::DIGIT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == rdf_pkg::DIV_STEP_WIDTH'(rdf_pkg::DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end else if (i_start) begin
            r_acc <= rdf_pkg::DIV_PAD_WIDTH'(i_dividend);
            r_rem <= '0;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_acc[rdf_pkg::WHOLE_WIDTH-1:0];
    assign o_remainder = r_rem;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_start_clears_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && i_start) |=> (r_busy && r_step == '0))
        else $error("divider did not start cleanly");
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ({1'b0, r_rem} < i_divisor)) else $error("remainder not below divisor");

endmodule

// ----- design/radix_digit_formatter.sv -----
// Radix digit formatter: writes a non-negative fixed-point number (31-bit whole part in
// s_axis_tdata[30:0], 32-bit binary fraction in s_axis_tdata[62:31]) as lower-case ASCII
// digits in the base held by the config register (2..16, reset 10; lower values act as 2,
// higher as 16), one character per m_axis transfer, most significant whole digit first.
// A nonzero fraction adds '.' and up to ten fraction digits, stopping once the fraction
// runs out; m_axis_tlast marks the final character. The whole part runs through the
// iterative divider once per whole digit (four steps of eight quotient bits each), and
// all whole digits are stored before the first is sent; each fraction character comes
// from one product of the 32x5 multiplier. s_axis_tready is high only while the
// formatter is idle; the base may only be written then.
module radix_digit_formatter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [rdf_pkg::BASE_WIDTH-1:0]        i_cfg_wr_data,   // base
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [rdf_pkg::IN_DATA_WIDTH-1:0]     s_axis_tdata,    // whole_part, fraction_part
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [rdf_pkg::OUT_DATA_WIDTH-1:0]    m_axis_tdata,    // out_char
    output logic                                  m_axis_tlast     // last_char
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_WHOLE = 5'b00100,
        S_POINT = 5'b01000,
        S_FRAC  = 5'b10000
    } t_state;

    t_state                                r_state, n_state;
    logic [rdf_pkg::BASE_WIDTH-1:0]        r_cfg_base;
    logic [rdf_pkg::BASE_WIDTH-1:0]        r_base, n_base;
    logic [rdf_pkg::FRACTION_WIDTH-1:0]    r_frac, n_frac;
    logic [rdf_pkg::COUNT_WIDTH-1:0]       r_cnt, n_cnt;
    logic [rdf_pkg::SENT_WIDTH-1:0]        r_sent, n_sent;
    logic [rdf_pkg::DIGIT_WIDTH-1:0]       r_store [rdf_pkg::WHOLE_WIDTH];
    logic [rdf_pkg::DIGIT_WIDTH-1:0]       r_rd_digit;

    logic                                  r_out_valid;
    logic [rdf_pkg::CHAR_WIDTH-1:0]        r_out_char;
    logic                                  r_out_last;

    logic                                  w_accept;
    logic                                  w_out_free;
    logic                                  w_emit;
    logic [rdf_pkg::CHAR_WIDTH-1:0]        w_char;
    logic                                  w_last;
    logic                                  w_store_we;
    logic [rdf_pkg::COUNT_WIDTH-1:0]       w_rd_idx;

    logic                                  w_div_start;
    logic [rdf_pkg::WHOLE_WIDTH-1:0]       w_div_dividend;
    logic                                  w_div_done;
    logic [rdf_pkg::WHOLE_WIDTH-1:0]       w_div_quot;
    logic [rdf_pkg::DIGIT_WIDTH-1:0]       w_div_rem;

    logic [rdf_pkg::PROD_WIDTH-1:0]        w_prod;
    logic [rdf_pkg::FRACTION_WIDTH-1:0]    w_rest;
    logic [rdf_pkg::DIGIT_WIDTH-1:0]       w_frac_digit;
    logic [rdf_pkg::COUNT_WIDTH-1:0]       w_cnt_m1;
    logic                                  w_frac_done;

    logic [rdf_pkg::BASE_WIDTH-1:0]        w_sat_base;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    always_comb begin
        if (r_cfg_base < rdf_pkg::BASE_MIN) begin
            w_sat_base = rdf_pkg::BASE_MIN;
        end else if (r_cfg_base > rdf_pkg::BASE_MAX) begin
            w_sat_base = rdf_pkg::BASE_MAX;
        end else begin
            w_sat_base = r_cfg_base;
        end
    end

    rdf_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dividend),
        .i_divisor   (r_base),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quot),
        .o_remainder (w_div_rem)
    );

    // fraction digit: integer part of fraction * base, product is < 16 * 2^32
    assign w_prod       = {{rdf_pkg::BASE_WIDTH{1'b0}}, r_frac}
                        * {{rdf_pkg::FRACTION_WIDTH{1'b0}}, r_base};
    assign w_rest       = w_prod[rdf_pkg::FRACTION_WIDTH-1:0];
    assign w_frac_digit = w_prod[rdf_pkg::FRACTION_WIDTH +: rdf_pkg::DIGIT_WIDTH];
    assign w_frac_done  = (w_rest == '0)
                        || (r_sent == rdf_pkg::SENT_WIDTH'(rdf_pkg::FRACTION_DIGITS - 1));
    assign w_cnt_m1     = r_cnt - 1'b1;
    // digit store is read at the next count, so the digit is ready in the cycle after
    assign w_rd_idx     = n_cnt - 1'b1;

    always_comb begin
        n_state        = r_state;
        n_base         = r_base;
        n_frac         = r_frac;
        n_cnt          = r_cnt;
        n_sent         = r_sent;
        w_emit         = 1'b0;
        w_char         = rdf_pkg::CHAR_POINT;
        w_last         = 1'b0;
        w_store_we     = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = w_div_quot;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_base         = w_sat_base;
                    n_frac         = s_axis_tdata[rdf_pkg::WHOLE_WIDTH +: rdf_pkg::FRACTION_WIDTH];
                    n_cnt          = '0;
                    n_sent         = '0;
                    w_div_start    = 1'b1;
                    w_div_dividend = s_axis_tdata[rdf_pkg::WHOLE_WIDTH-1:0];
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_store_we = 1'b1;
                    n_cnt      = r_cnt + 1'b1;
                    if (w_div_quot != '0) begin
                        w_div_start = 1'b1;
                    end else begin
                        n_state = S_WHOLE;
                    end
                end
            end
            S_WHOLE: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    w_char = rdf_pkg::digit_char(r_rd_digit);
                    w_last = (r_frac == '0) && (r_cnt == rdf_pkg::COUNT_WIDTH'(1));
                    n_cnt  = w_cnt_m1;
                    if (r_cnt == rdf_pkg::COUNT_WIDTH'(1)) begin
                        n_state = (r_frac != '0) ? S_POINT : S_IDLE;
                    end
                end
            end
            S_POINT: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    w_char  = rdf_pkg::CHAR_POINT;
                    n_state = S_FRAC;
                end
            end
            S_FRAC: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    w_char = rdf_pkg::digit_char(w_frac_digit);
                    w_last = w_frac_done;
                    n_frac = w_rest;
                    n_sent = r_sent + 1'b1;
                    if (w_frac_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_base  <= rdf_pkg::BASE_RESET;
            r_cnt       <= '0;
            r_sent      <= '0;
            r_frac      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sent  <= n_sent;
            r_frac  <= n_frac;
            if (i_cfg_wr_en) begin
                r_cfg_base <= i_cfg_wr_data;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        if (w_emit) begin
            r_out_char <= w_char;
            r_out_last <= w_last;
        end
        if (w_store_we) begin
            // the digit being written sits at the next read address
            r_store[r_cnt] <= w_div_rem;
            r_rd_digit     <= w_div_rem;
        end else if (n_cnt != '0) begin
            r_rd_digit <= r_store[w_rd_idx];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_last;

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DIV)) else $error("accepted item did not enter division");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= rdf_pkg::COUNT_WIDTH'(rdf_pkg::WHOLE_WIDTH)) else $error("digit count overflow");
    a_sent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sent <= rdf_pkg::SENT_WIDTH'(rdf_pkg::FRACTION_DIGITS))
        else $error("too many fraction digits");
    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_base >= rdf_pkg::BASE_MIN && r_base <= rdf_pkg::BASE_MAX))
        else $error("working base out of range");
    a_whole_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WHOLE) |-> (r_cnt != '0)) else $error("no whole digit to send");

endmodule

// ----- tb/rdf_digit_checker.sv -----
`timescale 1ns / 100ps

// Watches both stream channels and the base register writes, expands every accepted
// number into its expected character run and checks the output transfers in order.
module rdf_digit_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [rdf_pkg::BASE_WIDTH-1:0]     i_cfg_wr_data,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    input  logic [rdf_pkg::IN_DATA_WIDTH-1:0]  i_s_tdata,   // whole_part, fraction_part
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [rdf_pkg::OUT_DATA_WIDTH-1:0] i_m_tdata,   // out_char
    input  logic                               i_m_tlast,   // last_char
    output int                                 o_mismatches,
    output int                                 o_pending,
    output int                                 o_chars_seen
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char;

    t_char                        pending_chars[$];
    logic [rdf_pkg::BASE_WIDTH-1:0] base_reg;
    int                           mismatches;
    int                           chars_seen;

    function automatic logic [7:0] digit_ascii(input logic [3:0] d);
        if (d > 4'd9) begin
            return 8'h61 + {4'h0, d} - 8'd10;
        end
        return 8'h30 + {4'h0, d};
    endfunction

    // Appends the characters one number produces under the given base register value.
    function automatic void expand_number(input logic [30:0] whole, input logic [31:0] frac,
                                          input logic [4:0] base_val);
        logic [4:0]  radix;
        logic [3:0]  digits [0:30];
        logic [30:0] quot;
        logic [31:0] rest;
        logic [63:0] prod;
        logic [3:0]  d;
        int          n;
        int          sent;
        bit          has_frac;
        bit          done;
        t_char       c;

        // register values outside 2..16 saturate
        radix = base_val;
        if (radix < rdf_pkg::BASE_MIN) radix = rdf_pkg::BASE_MIN;
        if (radix > rdf_pkg::BASE_MAX) radix = rdf_pkg::BASE_MAX;

        quot = whole;
        n    = 0;
        do begin
            digits[n] = 4'(quot % radix);
            n++;
            quot = quot / radix;
        end while (quot != 0);

        rest     = frac;
        has_frac = (rest != 0);
        for (int i = n - 1; i >= 0; i--) begin
            c.ch   = digit_ascii(digits[i]);
            c.last = !has_frac && (i == 0);
            pending_chars.push_back(c);
        end

        if (has_frac) begin
            c.ch   = rdf_pkg::CHAR_POINT;
            c.last = 1'b0;
            pending_chars.push_back(c);
            sent = 0;
            do begin
                prod   = {32'h0, rest} * {59'h0, radix};
                d      = prod[35:32];
                rest   = prod[31:0];
                sent++;
                done   = (rest == 0) || (sent >= rdf_pkg::FRACTION_DIGITS);
                c.ch   = digit_ascii(d);
                c.last = done;
                pending_chars.push_back(c);
            end while (!done);
        end
    endfunction

    always @(posedge i_clk) begin
        t_char want;
        if (!i_rst_n) begin
            base_reg = rdf_pkg::BASE_RESET;
            pending_chars.delete();
        end else begin
            // a number taken at this edge still sees the old base
            if (i_s_tvalid && i_s_tready) begin
                expand_number(i_s_tdata[30:0], i_s_tdata[62:31], base_reg);
            end
            if (i_cfg_wr_en) base_reg = i_cfg_wr_data;
            if (i_m_tvalid && i_m_tready) begin
                chars_seen++;
                if (pending_chars.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, got char %h last %b",
                             $time, i_m_tdata, i_m_tlast);
                    mismatches++;
                end else begin
                    want = pending_chars.pop_front();
                    if (i_m_tdata !== want.ch) begin
                        $display("%0t: out_char expected %h got %h", $time, want.ch, i_m_tdata);
                        mismatches++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $display("%0t: last_char expected %b got %b",
                                 $time, want.last, i_m_tlast);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= pending_chars.size();
        o_mismatches <= mismatches;
        o_chars_seen <= chars_seen;
    end

endmodule

// ----- tb/radix_digit_formatter_tb.sv -----
`timescale 1ns / 100ps

module radix_digit_formatter_tb;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 30;
    localparam int PHASE_COUNT  = 9;
    localparam int TAIL_CYCLES  = 200;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_wr_en = 1'b0;
    logic [rdf_pkg::BASE_WIDTH-1:0]      i_cfg_wr_data = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [rdf_pkg::IN_DATA_WIDTH-1:0]   s_axis_tdata = '0;   // whole_part, fraction_part
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [rdf_pkg::OUT_DATA_WIDTH-1:0]  m_axis_tdata;        // out_char
    logic                                m_axis_tlast;        // last_char

    int mismatches;
    int pending;
    int chars_seen;
    int cycle_count = 0;
    int numbers_sent = 0;
    int base_writes = 0;
    bit quiet = 1'b0;

    radix_digit_formatter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    rdf_digit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tlast     (m_axis_tlast),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_chars_seen  (chars_seen)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // output side: random stall bursts, none once quiet is set
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    // Returns at the edge where the number was taken; the caller drives the next value
    // in that same step.
    task automatic push_number(input logic [30:0] whole, input logic [31:0] frac);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rdf_pkg::IN_DATA_WIDTH'({frac, whole});
        do @(posedge i_clk); while (!s_axis_tready);
        numbers_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // base may only change while the formatter is idle
    task automatic write_base(input logic [rdf_pkg::BASE_WIDTH-1:0] value);
        wait_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        base_writes++;
    endtask

    task automatic push_random_number();
        logic [30:0] whole;
        logic [31:0] frac;
        case ($urandom_range(0, 3))
            0:       whole = 31'($urandom_range(0, 20));
            1:       whole = 31'($urandom);
            default: whole = 31'($urandom) >> $urandom_range(0, 30);
        endcase
        case ($urandom_range(0, 5))
            0:       frac = '0;
            // only a few top bits set: in an even base the expansion ends before ten digits
            1:       frac = $urandom & (32'hffffffff << $urandom_range(24, 31));
            default: frac = $urandom;
        endcase
        push_number(whole, frac);
    endtask

    initial begin
        logic [rdf_pkg::BASE_WIDTH-1:0] phase_base [PHASE_COUNT];

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset base ten
        push_number(31'd0, 32'h0);
        push_number(31'h7fffffff, 32'h0);
        push_number(31'd0, 32'hffffffff);
        push_number(31'h7fffffff, 32'hffffffff);
        push_number(31'd0, 32'h80000000);
        push_number(31'd9, 32'h00000001);
        push_number(31'd10, 32'h40000000);

        // zero and one saturate to base two; full input gives the longest run
        write_base(5'd0);
        push_number(31'h7fffffff, 32'hffffffff);
        push_number(31'd0, 32'h0);
        write_base(5'd1);
        push_number(31'd5, 32'hc0000000);
        write_base(5'd2);
        push_number(31'h2aaaaaaa, 32'h55555555);
        write_base(5'd16);
        push_number(31'h7fffffff, 32'hffffffff);
        push_number(31'h40000000, 32'h00000010);
        // above sixteen saturates to hex
        write_base(5'd17);
        push_number(31'h12345678, 32'hdeadbeef);
        write_base(5'd31);
        push_number(31'd255, 32'h00000001);
        write_base(5'd3);
        push_number(31'h7fffffff, 32'h55555555);
        write_base(5'd7);
        push_number(31'd48, 32'h80000000);

        phase_base[0] = 5'd2;
        phase_base[1] = 5'd16;
        phase_base[2] = 5'd31;
        phase_base[3] = 5'd0;
        phase_base[4] = 5'd10;
        phase_base[5] = 5'd8;
        phase_base[6] = 5'($urandom_range(3, 15));
        phase_base[7] = 5'($urandom_range(17, 31));
        phase_base[8] = 5'($urandom_range(0, 31));

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_base(phase_base[p]);
            if (p == PHASE_COUNT - 1) quiet = 1'b1;
            repeat (PHASE_ITEMS) push_random_number();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d numbers formatted into %0d characters across %0d base register writes,",
                 numbers_sent, chars_seen, base_writes);
        $display("bases two to sixteen plus saturating values zero, one, 17 and 31");
        if (mismatches == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
